FILE: rtl/imk_pkg.sv
// shared types, codes and defaults for the iambic morse keyer
package imk_pkg;

  // default parameter values
  localparam int MAX_DIT_TICKS_DEF = 1200;
  localparam int PAUSE_WINDOW_DEF  = 2000;

  // fixed field widths
  localparam int DIT_W   = 11;
  localparam int PAUSE_W = 11;

  // input commands
  localparam logic [1:0] CMD_DIT  = 2'd0;
  localparam logic [1:0] CMD_DAH  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // result events
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_SPACE = 2'd2;

  // reported phase codes
  localparam logic [1:0] KP_IDLE = 2'd0;
  localparam logic [1:0] KP_DIT  = 2'd1;
  localparam logic [1:0] KP_DAH  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLED  = 2'd0;
  localparam logic [1:0] REG_MODE     = 2'd1;
  localparam logic [1:0] REG_REVERSED = 2'd2;
  localparam logic [1:0] REG_DIT      = 2'd3;

  // keyer element state
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DIT  = 3'b010,
    PH_DAH  = 3'b100
  } imk_phase_t;

  typedef struct packed {
    logic             enabled;
    logic             mode;
    logic             reversed;
    logic [DIT_W-1:0] dit_ticks;
  } imk_cfg_t;

  typedef struct packed {
    logic       dit_level;
    logic       dah_level;
    logic       dit_mem;
    logic       dah_mem;
    logic       squeeze;
    logic       idle_known;
    imk_phase_t phase;
  } imk_flags_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic               is_dit;
    logic               pause_valid;
    logic [PAUSE_W-1:0] pause_ticks;
    logic [1:0]         keyer_phase;
  } imk_res_t;

endpackage

FILE: rtl/imk_step.sv
// next-state and result logic for one keyer beat
module imk_step #(
  parameter int MAX_DIT_TICKS = imk_pkg::MAX_DIT_TICKS_DEF,
  parameter int PAUSE_WINDOW  = imk_pkg::PAUSE_WINDOW_DEF,
  localparam int TICK_W = $clog2(4 * MAX_DIT_TICKS + 1),
  localparam int IDLE_W = $clog2(PAUSE_WINDOW + 2)
) (
  input  imk_pkg::imk_cfg_t   cfg,
  input  imk_pkg::imk_flags_t flags_q,
  input  logic [TICK_W-1:0]   ticks_q,
  input  logic [IDLE_W-1:0]   idle_q,
  input  logic [1:0]          command,
  input  logic                pressed,
  output imk_pkg::imk_flags_t flags_next,
  output logic [TICK_W-1:0]   ticks_next,
  output logic [IDLE_W-1:0]   idle_next,
  output imk_pkg::imk_res_t   res
);

  localparam int CMP_W = (TICK_W > imk_pkg::DIT_W) ? TICK_W : imk_pkg::DIT_W;

  logic [CMP_W-1:0]         dit_ext;
  logic [CMP_W-1:0]         len;
  logic [IDLE_W+10:0]       idle_wide;
  logic                     ld, lh, d, h;
  logic                     was_dit;
  logic                     start_go, start_dit, idle_go;

  // clamp the dit length into 1..MAX_DIT_TICKS
  always_comb begin
    dit_ext = CMP_W'(cfg.dit_ticks);
    if (dit_ext == '0) begin
      len = CMP_W'(1);
    end else if (dit_ext > CMP_W'(MAX_DIT_TICKS)) begin
      len = CMP_W'(MAX_DIT_TICKS);
    end else begin
      len = dit_ext;
    end
  end

  assign idle_wide = {{imk_pkg::PAUSE_W{1'b0}}, idle_q};

  always_comb begin
    flags_next = flags_q;
    ticks_next = ticks_q;
    idle_next  = idle_q;
    res        = '0;
    start_go   = 1'b0;
    start_dit  = 1'b0;
    idle_go    = 1'b0;

    case (command)
      imk_pkg::CMD_DIT: begin
        flags_next.dit_level = pressed;
        if (pressed) flags_next.dit_mem = 1'b1;
      end
      imk_pkg::CMD_DAH: begin
        flags_next.dah_level = pressed;
        if (pressed) flags_next.dah_mem = 1'b1;
      end
      default: ;
    endcase

    // logical paddles after the level update
    ld = cfg.reversed ? flags_next.dah_level : flags_next.dit_level;
    lh = cfg.reversed ? flags_next.dit_level : flags_next.dah_level;
    d  = ld | (cfg.reversed ? flags_next.dah_mem : flags_next.dit_mem);
    h  = lh | (cfg.reversed ? flags_next.dit_mem : flags_next.dah_mem);
    was_dit = (flags_q.phase == imk_pkg::PH_DIT);

    case (command)
      imk_pkg::CMD_DIT, imk_pkg::CMD_DAH: begin
        if (cfg.enabled) begin
          if (flags_q.phase != imk_pkg::PH_IDLE) begin
            if (d && h) flags_next.squeeze = 1'b1;
          end else if (d) begin
            start_go  = 1'b1;
            start_dit = 1'b1;
          end else if (h) begin
            start_go  = 1'b1;
          end
        end
      end
      imk_pkg::CMD_TICK: begin
        if (flags_q.phase == imk_pkg::PH_IDLE) begin
          if (flags_q.idle_known && idle_q <= IDLE_W'(PAUSE_WINDOW))
            idle_next = idle_q + IDLE_W'(1);
        end else if (ticks_q <= TICK_W'(1)) begin
          ticks_next = '0;
          // slot end: iambic choice of the next element
          if (flags_q.squeeze && !ld && !lh) begin
            if (cfg.mode) begin
              start_go  = 1'b1;
              start_dit = !was_dit;
            end else begin
              idle_go = 1'b1;
            end
          end else if (d && h) begin
            start_go  = 1'b1;
            start_dit = !was_dit;
          end else if (d) begin
            start_go  = 1'b1;
            start_dit = 1'b1;
          end else if (h) begin
            start_go  = 1'b1;
          end else if (flags_q.squeeze && cfg.mode) begin
            start_go  = 1'b1;
            start_dit = !was_dit;
          end else begin
            idle_go = 1'b1;
          end
        end else begin
          ticks_next = ticks_q - TICK_W'(1);
        end
      end
      default: ;
    endcase

    if (start_go) begin
      if (flags_q.phase == imk_pkg::PH_IDLE && flags_q.idle_known &&
          idle_q <= IDLE_W'(PAUSE_WINDOW)) begin
        res.pause_valid = 1'b1;
        res.pause_ticks = idle_wide[imk_pkg::PAUSE_W-1:0];
      end
      flags_next.phase = start_dit ? imk_pkg::PH_DIT : imk_pkg::PH_DAH;
      if (start_dit != cfg.reversed) flags_next.dit_mem = 1'b0;
      else                           flags_next.dah_mem = 1'b0;
      flags_next.squeeze = ld && lh;
      ticks_next = start_dit ? TICK_W'(len << 1) : TICK_W'(len << 2);
      res.event_res = imk_pkg::EV_START;
      res.is_dit    = start_dit;
    end

    if (idle_go) begin
      flags_next.phase      = imk_pkg::PH_IDLE;
      flags_next.squeeze    = 1'b0;
      flags_next.dit_mem    = 1'b0;
      flags_next.dah_mem    = 1'b0;
      flags_next.idle_known = 1'b1;
      ticks_next = '0;
      idle_next  = '0;
      res.event_res = imk_pkg::EV_SPACE;
    end

    case (flags_next.phase)
      imk_pkg::PH_DIT: res.keyer_phase = imk_pkg::KP_DIT;
      imk_pkg::PH_DAH: res.keyer_phase = imk_pkg::KP_DAH;
      default:         res.keyer_phase = imk_pkg::KP_IDLE;
    endcase
  end

endmodule

FILE: rtl/iambic_morse_keyer.sv
// iambic morse keyer (modes a and b) top level
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_stall    command, pressed
//  out      out  out_valid / out_stall  event_res, element_is_dit, pause_valid,
//                                       pause_ticks, keyer_phase
//  cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result beat per input beat, one beat per cycle sustained while out_stall stays low
// a beat passes the input register, then keyer logic into the output register
// keyer state updates in the same cycle the result register loads
// out_stall holds the result register; the input register keeps taking a beat
//   while empty, so one beat waits in each stage
// rst (synchronous) clears the pipeline valids, keyer state and config defaults
module iambic_morse_keyer #(
  parameter int MAX_DIT_TICKS = imk_pkg::MAX_DIT_TICKS_DEF,
  parameter int PAUSE_WINDOW  = imk_pkg::PAUSE_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic        pressed,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic        element_is_dit,
  output logic        pause_valid,
  output logic [10:0] pause_ticks,
  output logic [1:0]  keyer_phase,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int TICK_W = $clog2(4 * MAX_DIT_TICKS + 1);
  localparam int IDLE_W = $clog2(PAUSE_WINDOW + 2);

  // config registers
  imk_pkg::imk_cfg_t   cfg;

  // input stage
  logic                s1_valid;
  logic [1:0]          s1_command;
  logic                s1_pressed;

  // keyer state
  imk_pkg::imk_flags_t flags;
  imk_pkg::imk_flags_t flags_next;
  logic [TICK_W-1:0]   ticks_left;
  logic [TICK_W-1:0]   ticks_left_next;
  logic [IDLE_W-1:0]   idle_count;
  logic [IDLE_W-1:0]   idle_count_next;

  // result register
  imk_pkg::imk_res_t   res_next;
  imk_pkg::imk_res_t   res;

  logic                advance;

  // output register frees up when empty or taken this cycle
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  // config writes, only issued while the keyer is quiet: the user keeps to this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled   <= 1'b1;
      cfg.mode      <= 1'b0;
      cfg.reversed  <= 1'b0;
      cfg.dit_ticks <= 11'd60;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        imk_pkg::REG_ENABLED:  cfg.enabled   <= cfg_data[0];
        imk_pkg::REG_MODE:     cfg.mode      <= cfg_data[0];
        imk_pkg::REG_REVERSED: cfg.reversed  <= cfg_data[0];
        imk_pkg::REG_DIT:      cfg.dit_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command <= command;
      s1_pressed <= pressed;
    end
  end

  imk_step #(
    .MAX_DIT_TICKS (MAX_DIT_TICKS),
    .PAUSE_WINDOW  (PAUSE_WINDOW)
  ) u_step (
    .cfg        (cfg),
    .flags_q    (flags),
    .ticks_q    (ticks_left),
    .idle_q     (idle_count),
    .command    (s1_command),
    .pressed    (s1_pressed),
    .flags_next (flags_next),
    .ticks_next (ticks_left_next),
    .idle_next  (idle_count_next),
    .res        (res_next)
  );

  // keyer state moves only when a beat crosses into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags.dit_level  <= 1'b0;
      flags.dah_level  <= 1'b0;
      flags.dit_mem    <= 1'b0;
      flags.dah_mem    <= 1'b0;
      flags.squeeze    <= 1'b0;
      flags.idle_known <= 1'b0;
      flags.phase      <= imk_pkg::PH_IDLE;
      ticks_left       <= '0;
      idle_count       <= '0;
      out_valid        <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        flags      <= flags_next;
        ticks_left <= ticks_left_next;
        idle_count <= idle_count_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res <= res_next;
    end
  end

  assign event_res      = res.event_res;
  assign element_is_dit = res.is_dit;
  assign pause_valid    = res.pause_valid;
  assign pause_ticks    = res.pause_ticks;
  assign keyer_phase    = res.keyer_phase;

`ifndef ASSERT_OFF
  // a running element always has ticks left, idle never does
  a_ticks_phase: assert property (@(posedge clk) disable iff (rst)
    (flags.phase == imk_pkg::PH_IDLE) == (ticks_left == '0))
    else $error("ticks_left out of step with phase");

  // idle counter saturates one past the pause window
  a_idle_sat: assert property (@(posedge clk) disable iff (rst)
    idle_count <= IDLE_W'(PAUSE_WINDOW + 1))
    else $error("idle_count past saturation");

  // a started element shows a playing phase
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == imk_pkg::EV_START |-> keyer_phase != imk_pkg::KP_IDLE)
    else $error("element start with idle phase");

  // a character space leaves the keyer idle
  a_space_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == imk_pkg::EV_SPACE |-> keyer_phase == imk_pkg::KP_IDLE)
    else $error("character space with playing phase");

  // a pause is only reported with an element start
  a_pause_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && pause_valid |-> event_res == imk_pkg::EV_START)
    else $error("pause reported without element start");

  // input stage only stalls while it holds a beat
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled while empty");
`endif

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the iambic morse keyer: paddle and tick beats in, one result per beat
module testbench;

  // codes the package does not name
  localparam logic [1:0] CMD_BAD = 2'd3;   // unused command, keyer must ignore it
  localparam logic       MODE_A  = 1'b0;
  localparam logic       MODE_B  = 1'b1;

  localparam int MAX_DIT   = imk_pkg::MAX_DIT_TICKS_DEF;
  localparam int PAUSE_WIN = imk_pkg::PAUSE_WINDOW_DEF;

  typedef struct packed {
    logic [1:0] cmd;
    logic       pr;
  } paddle_beat_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command  = imk_pkg::CMD_TICK;
  logic        pressed  = 1'b0;

  // result channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic        element_is_dit;
  logic        pause_valid;
  logic [10:0] pause_ticks;
  logic [1:0]  keyer_phase;

  // register writes
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = imk_pkg::REG_ENABLED;
  logic [10:0] cfg_data  = '0;

  iambic_morse_keyer DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .pressed        (pressed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .element_is_dit (element_is_dit),
    .pause_valid    (pause_valid),
    .pause_ticks    (pause_ticks),
    .keyer_phase    (keyer_phase),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the keyer hangs or drops a result
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // keyer prediction: shadow registers and keyer state, advanced once per
  // accepted beat, in the same order the block sees them
  // ---------------------------------------------------------------------------
  logic        cfg_en   = 1'b1;
  logic        cfg_mode = MODE_A;
  logic        cfg_rev  = 1'b0;
  logic [10:0] cfg_dit  = 11'd60;

  logic        lvl_dit = 1'b0, lvl_dah = 1'b0;       // physical paddle levels
  logic        mem_dit_r = 1'b0, mem_dah_r = 1'b0;   // physical press latches
  logic [1:0]  kp = imk_pkg::KP_IDLE;
  logic        squeeze_f = 1'b0;
  logic [12:0] left = '0;
  logic [10:0] idle_cnt = '0;
  logic        idle_seen = 1'b0;
  imk_pkg::imk_res_t res_w;

  // logical paddles after the optional swap
  function automatic logic dit_held();
    return cfg_rev ? lvl_dah : lvl_dit;
  endfunction

  function automatic logic dah_held();
    return cfg_rev ? lvl_dit : lvl_dah;
  endfunction

  function automatic logic dit_latched();
    return cfg_rev ? mem_dah_r : mem_dit_r;
  endfunction

  function automatic logic dah_latched();
    return cfg_rev ? mem_dit_r : mem_dah_r;
  endfunction

  function automatic void launch_element(logic to_dit);
    logic [12:0] len;
    if (cfg_dit == 0) len = 13'd1;
    else if (cfg_dit > MAX_DIT) len = 13'(MAX_DIT);
    else len = 13'(cfg_dit);
    // pause only counts when coming out of a known idle stretch
    if (kp == imk_pkg::KP_IDLE && idle_seen && idle_cnt <= PAUSE_WIN) begin
      res_w.pause_valid = 1'b1;
      res_w.pause_ticks = idle_cnt;
    end
    kp = to_dit ? imk_pkg::KP_DIT : imk_pkg::KP_DAH;
    // the latch of the logical paddle now playing is consumed
    if (to_dit != cfg_rev) mem_dit_r = 1'b0;
    else mem_dah_r = 1'b0;
    squeeze_f = dit_held() && dah_held();
    left = to_dit ? 13'(len * 2) : 13'(len * 4);
    res_w.event_res = imk_pkg::EV_START;
    res_w.is_dit = to_dit;
  endfunction

  function automatic void drop_to_idle();
    kp = imk_pkg::KP_IDLE;
    left = '0;
    squeeze_f = 1'b0;
    mem_dit_r = 1'b0;
    mem_dah_r = 1'b0;
    idle_cnt = '0;
    idle_seen = 1'b1;
    res_w.event_res = imk_pkg::EV_SPACE;
  endfunction

  function automatic void paddle_update();
    logic d, h;
    if (!cfg_en) return;
    d = dit_held() | dit_latched();
    h = dah_held() | dah_latched();
    if (kp != imk_pkg::KP_IDLE) begin
      if (d && h) squeeze_f = 1'b1;
    end else if (d) begin
      launch_element(1'b1);
    end else if (h) begin
      launch_element(1'b0);
    end
  endfunction

  // iambic choice at the end of a slot
  function automatic void close_slot();
    logic ld, lh, d, h, was_dit;
    ld = dit_held();
    lh = dah_held();
    d = ld | dit_latched();
    h = lh | dah_latched();
    was_dit = (kp == imk_pkg::KP_DIT);
    if (squeeze_f && !ld && !lh) begin
      if (cfg_mode == MODE_B) launch_element(!was_dit);
      else drop_to_idle();
    end else if (d && h) begin
      launch_element(!was_dit);
    end else if (d) begin
      launch_element(1'b1);
    end else if (h) begin
      launch_element(1'b0);
    end else if (squeeze_f && cfg_mode == MODE_B) begin
      launch_element(!was_dit);
    end else begin
      drop_to_idle();
    end
  endfunction

  function automatic imk_pkg::imk_res_t keyer_predict(logic [1:0] cmd, logic pr);
    res_w = '0;
    case (cmd)
      imk_pkg::CMD_DIT: begin
        lvl_dit = pr;
        if (pr) mem_dit_r = 1'b1;
        paddle_update();
      end
      imk_pkg::CMD_DAH: begin
        lvl_dah = pr;
        if (pr) mem_dah_r = 1'b1;
        paddle_update();
      end
      imk_pkg::CMD_TICK: begin
        if (kp == imk_pkg::KP_IDLE) begin
          // counts only after the first idle entry, stops one past the window
          if (idle_seen && idle_cnt <= PAUSE_WIN) idle_cnt++;
        end else if (left <= 1) begin
          left = '0;
          close_slot();
        end else begin
          left--;
        end
      end
      default: ;
    endcase
    res_w.keyer_phase = kp;
    return res_w;
  endfunction

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  paddle_beat_t      pending_q[$];
  imk_pkg::imk_res_t expected_q[$];
  bit           gaps_on = 1'b1;
  bit           random_started = 1'b0;
  logic         hold_off = 1'b0;
  int           mismatches = 0;
  int           beats_queued = 0;
  int           beats_sent = 0;
  int           results_checked = 0;
  int           starts_seen = 0, spaces_seen = 0, pauses_seen = 0;
  int           input_stalls = 0;
  int           settings_used = 0;

  task automatic note_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued beats, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    paddle_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(keyer_predict(command, pressed));
      if (in_valid && in_stall) input_stalls++;
      // a stalled beat stays put; otherwise pick gap or next beat
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          nxt = pending_q.pop_front();
          beats_sent++;
          command  <= nxt.cmd;
          pressed  <= nxt.pr;
          in_valid <= 1'b1;
          send_gap = gaps_on ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  int recv_gap = 0;

  always @(posedge clk) begin
    imk_pkg::imk_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          note_mismatch("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (event_res !== want.event_res)
            note_mismatch($sformatf("beat %0d event_res %0d, want %0d",
                                    results_checked, event_res, want.event_res));
          if (element_is_dit !== want.is_dit)
            note_mismatch($sformatf("beat %0d element_is_dit %0b, want %0b",
                                    results_checked, element_is_dit, want.is_dit));
          if (pause_valid !== want.pause_valid)
            note_mismatch($sformatf("beat %0d pause_valid %0b, want %0b",
                                    results_checked, pause_valid, want.pause_valid));
          if (pause_ticks !== want.pause_ticks)
            note_mismatch($sformatf("beat %0d pause_ticks %0d, want %0d",
                                    results_checked, pause_ticks, want.pause_ticks));
          if (keyer_phase !== want.keyer_phase)
            note_mismatch($sformatf("beat %0d keyer_phase %0d, want %0d",
                                    results_checked, keyer_phase, want.keyer_phase));
          if (want.event_res == imk_pkg::EV_START) starts_seen++;
          if (want.event_res == imk_pkg::EV_SPACE) spaces_seen++;
          if (want.pause_valid) pauses_seen++;
        end
        results_checked++;
      end
      // long hold-off wins over the random stall pattern
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        if (recv_gap == 0 && gaps_on) recv_gap = gap_len();
        out_stall <= (recv_gap != 0);
        if (recv_gap != 0) recv_gap--;
      end
    end
  end

  // receiver holds off long enough to fill both pipeline stages and back up
  // the item channel while the driver keeps offering
  initial begin
    wait (random_started);
    repeat ($urandom_range(20, 60)) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] cmd, input logic pr);
    pending_q.push_back('{cmd: cmd, pr: pr});
    if (cmd != CMD_BAD) beats_queued++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_item(imk_pkg::CMD_TICK, 1'b0);
  endtask

  // wait until every beat sent has come back as a result, then let the
  // two-stage pipeline settle
  task automatic drain();
    while (pending_q.size() != 0 || beats_sent > results_checked) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      imk_pkg::REG_ENABLED:  cfg_en   = val[0];
      imk_pkg::REG_MODE:     cfg_mode = val[0];
      imk_pkg::REG_REVERSED: cfg_rev  = val[0];
      imk_pkg::REG_DIT:      cfg_dit  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic md, input logic rev,
                            input logic [10:0] dit);
    drain();
    write_reg(imk_pkg::REG_ENABLED, {10'd0, en});
    write_reg(imk_pkg::REG_MODE, {10'd0, md});
    write_reg(imk_pkg::REG_REVERSED, {10'd0, rev});
    write_reg(imk_pkg::REG_DIT, dit);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // random phase: mostly keyed characters (press, squeeze, hold, release,
  // let the slots run out) with stray paddle changes, idle runs and noise
  task automatic queue_random_phase(input int want, input int dit_len);
    int target, r, lim;
    logic [1:0] first, other;
    bit squeezed;
    target = beats_queued + want;
    lim = 4 * ((dit_len == 0) ? 1 : dit_len) + 2;
    while (beats_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        push_item(CMD_BAD, 1'($urandom_range(0, 1)));
      end else if (r < 60) begin
        first = $urandom_range(0, 1) ? imk_pkg::CMD_DAH : imk_pkg::CMD_DIT;
        other = (first == imk_pkg::CMD_DIT) ? imk_pkg::CMD_DAH : imk_pkg::CMD_DIT;
        squeezed = ($urandom_range(0, 2) == 0);
        push_item(first, 1'b1);
        if (squeezed) begin
          push_ticks($urandom_range(0, 2));
          push_item(other, 1'b1);
        end
        push_ticks($urandom_range(0, lim));
        // release order varies so squeeze exits from both sides get hit
        if (squeezed && $urandom_range(0, 1)) begin
          push_item(other, 1'b0);
          push_ticks($urandom_range(0, 2));
          push_item(first, 1'b0);
        end else begin
          push_item(first, 1'b0);
          if (squeezed) push_item(other, 1'b0);
        end
        push_ticks($urandom_range(0, 2 * lim));
      end else if (r < 80) begin
        push_item($urandom_range(0, 1) ? imk_pkg::CMD_DAH : imk_pkg::CMD_DIT,
                  1'($urandom_range(0, 1)));
      end else if (r < 95) begin
        push_ticks($urandom_range(1, lim));
      end else begin
        push_ticks($urandom_range(20, 60));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int dit_len, r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // iambic A, shortest dit: ignored command, ticks before the first idle,
    // start with no pause report, plain space, timed pause, squeeze let go
    set_config(1'b1, MODE_A, 1'b0, 11'd1);
    push_item(CMD_BAD, 1'b1);
    push_item(CMD_BAD, 1'b0);
    push_ticks(1);
    push_item(imk_pkg::CMD_DIT, 1'b1);
    push_item(imk_pkg::CMD_DIT, 1'b0);
    push_ticks(5);
    push_item(imk_pkg::CMD_DAH, 1'b1);
    push_item(imk_pkg::CMD_DIT, 1'b1);
    push_item(imk_pkg::CMD_DIT, 1'b0);
    push_item(imk_pkg::CMD_DAH, 1'b0);
    push_ticks(4);

    // iambic B with swapped paddles and a zero dit length (runs as one tick):
    // squeeze released mid-slot must still add the opposite element
    set_config(1'b1, MODE_B, 1'b1, 11'd0);
    push_item(imk_pkg::CMD_DIT, 1'b1);
    push_item(imk_pkg::CMD_DAH, 1'b1);
    push_item(imk_pkg::CMD_DIT, 1'b0);
    push_item(imk_pkg::CMD_DAH, 1'b0);
    push_ticks(8);

    // stretch with no idling on either side: timed pause out of idle, then
    // a held paddle chains slots back to back until released
    set_config(1'b1, MODE_A, 1'b0, 11'd3);
    gaps_on = 1'b0;
    push_ticks(30);
    push_item(imk_pkg::CMD_DAH, 1'b1);
    push_ticks(20);
    push_item(imk_pkg::CMD_DAH, 1'b0);
    push_ticks(20);

    // disabled: levels and latches move but nothing starts
    set_config(1'b0, MODE_B, 1'b0, 11'd2);
    gaps_on = 1'b1;
    push_item(imk_pkg::CMD_DAH, 1'b1);
    push_ticks(2);
    push_item(imk_pkg::CMD_DAH, 1'b0);
    push_item(imk_pkg::CMD_DIT, 1'b1);
    push_item(imk_pkg::CMD_DIT, 1'b0);

    // random settings, mostly short dits so slots end often
    for (int ph = 0; ph < 8; ph++) begin
      r = $urandom_range(0, 9);
      dit_len = (r < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      gaps_on = (ph % 4 != 3);
      set_config(($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 11'(dit_len));
      queue_random_phase(85, dit_len);
      if (ph == 0) random_started = 1'b1;
    end

    drain();
    $display("covered %0d keyer beats over %0d register settings, %0d input stall cycles",
             results_checked, settings_used, input_stalls);
    $display("saw %0d element starts, %0d character spaces, %0d pause reports",
             starts_seen, spaces_seen, pauses_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/imk_pkg.sv
rtl/imk_step.sv
rtl/iambic_morse_keyer.sv
sim/testbench.sv
